/* design/priority_ready_queue_scheduler_assert.svh */
// assertion macros used by the checker file
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define PRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after a reset edge
`define PRQ_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

/* design/prq_pkg.sv */
`timescale 1ns / 1ps
package prq_pkg;

  localparam int TID_W  = 6;
  localparam int PRIO_W = 5;
  localparam int LOCK_W = 16;
  localparam int FUNC_W = 3;

  localparam logic [LOCK_W-1:0] LOCK_MAX   = 16'hFFFF;
  localparam logic [PRIO_W-1:0] PRIO_RESET = 5'd31;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SCHED  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOCK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_UNLOCK = 3'd4;
  localparam logic [FUNC_W-1:0] FN_START  = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  thread_id;
    logic [PRIO_W-1:0] priority_req;
    logic              in_interrupt;
  } prq_in_t;

  typedef struct packed {
    logic              switched;
    logic              switch_from_irq;
    logic [TID_W-1:0]  to_thread;
    logic [TID_W-1:0]  from_tid;
    logic              from_valid;
    logic [PRIO_W-1:0] running_priority;
    logic [LOCK_W-1:0] lock_level;
    logic              none_ready;
  } prq_out_t;

endpackage

/* design/prq_ram.sv */
`timescale 1ns / 1ps
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wmask,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // bit-masked write, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem_r[waddr][i] <= wdata[i];
        end
      end
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/prq_lsb.sv */
`timescale 1ns / 1ps
module prq_lsb #(
  parameter int N  = 32,
  parameter int IW = $clog2(N)
) (
  input  logic [N-1:0]  bits,
  output logic [IW-1:0] idx,
  output logic          any
);

  // lowest set bit wins, scan from the top down
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign any = |bits;

endmodule

/* design/priority_ready_queue_scheduler.sv */
`timescale 1ns / 1ps
// Ready-queue scheduler: one FIFO of thread ids per priority level (0 highest),
// kept as doubly linked lists in two memories, with a ready bitmap of levels.
// Input channel: in_data carries func, thread_id, priority_req, in_interrupt;
// an item is taken at a rising edge with start high and busy low.
// Result channel: exactly one result per item, shown on out_data for a single
// cycle with out_valid high. The receiver cannot stall; results are never held.
// States from accept to result; the next item may be taken in the strobe cycle:
//   lock, bare unlock, ignored ops, empty or locked schedule   S_EXEC
//   schedule, start, unlock with schedule          S_EXEC, S_SCH_WAIT
//   insert into an empty level                     S_EXEC
//   insert into a non-empty level                  S_EXEC, S_INS_TAIL, S_INS_NEW
//   remove of a queued thread                      S_EXEC, S_REM_LINK, S_REM_LIST,
//                                                  then S_REM_PREV for a middle one
// The steps are set by the registered read of the list and link memories and by
// the single write port of the link memory, which takes one link update a cycle.
// Reset (synchronous, rst_n low) empties the bitmap, clears the queued flags,
// lock count and running thread, and sets the running priority to 31. The
// memories need no clearing: an entry is only read after it has been written.
module priority_ready_queue_scheduler #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int MAX_THREADS     = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  prq_pkg::prq_in_t  in_data,
  output logic              out_valid,
  output prq_pkg::prq_out_t out_data
);
  import prq_pkg::*;

  localparam int PW  = $clog2(PRIORITY_LEVELS);
  localparam int TW  = $clog2(MAX_THREADS);
  localparam int LSW = 2 * TW;
  localparam int LKW = 2 * TW + PW;

  // list entry {head, tail}, link entry {next, prev, level}
  localparam logic [LSW-1:0] LS_HEAD = {{TW{1'b1}}, {TW{1'b0}}};
  localparam logic [LSW-1:0] LS_TAIL = {{TW{1'b0}}, {TW{1'b1}}};
  localparam logic [LKW-1:0] LK_NEXT = {{TW{1'b1}}, {TW{1'b0}}, {PW{1'b0}}};
  localparam logic [LKW-1:0] LK_PREV = {{TW{1'b0}}, {TW{1'b1}}, {PW{1'b0}}};
  localparam logic [LKW-1:0] LK_ALL  = {LKW{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INS_TAIL,
    S_INS_NEW,
    S_REM_LINK,
    S_REM_LIST,
    S_REM_PREV,
    S_SCH_WAIT
  } state_t;

  state_t               state_r, state_nxt;
  prq_in_t              item_r, item_nxt;
  logic [PRIORITY_LEVELS-1:0] bitmap_r, bitmap_nxt;
  logic [MAX_THREADS-1:0]     queued_r, queued_nxt;
  logic [TW-1:0]        run_tid_r, run_tid_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [PRIO_W-1:0]    run_prio_r, run_prio_nxt;
  logic [LOCK_W-1:0]    lock_r, lock_nxt;
  logic [TW-1:0]        last_r, last_nxt;
  logic [TW-1:0]        nx_r, nx_nxt;
  logic [TW-1:0]        pv_r, pv_nxt;
  logic [PW-1:0]        lvl_r, lvl_nxt;
  prq_out_t             out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 list_we, list_re;
  logic [PW-1:0]        list_waddr, list_raddr;
  logic [LSW-1:0]       list_wmask, list_wdata, list_rdata;
  logic                 link_we, link_re;
  logic [TW-1:0]        link_waddr, link_raddr;
  logic [LKW-1:0]       link_wmask, link_wdata, link_rdata;

  logic [PW-1:0]        lsb_idx;
  logic                 lsb_any;

  logic [TW-1:0]        tid;
  logic [PW-1:0]        prio;
  logic                 tid_ok, prio_ok;
  logic [TW-1:0]        ls_head, ls_tail, lk_next, lk_prev;
  logic [PW-1:0]        lk_lvl;
  logic                 is_head, is_tail, is_start;
  logic [LOCK_W-1:0]    lock_dec;
  logic                 fin, sched_go;
  prq_out_t             res;

  prq_ram #(.WIDTH(LSW), .DEPTH(PRIORITY_LEVELS)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wmask (list_wmask),
    .wdata (list_wdata),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  prq_ram #(.WIDTH(LKW), .DEPTH(MAX_THREADS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wmask (link_wmask),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  prq_lsb #(.N(PRIORITY_LEVELS)) u_lsb (
    .bits (bitmap_r),
    .idx  (lsb_idx),
    .any  (lsb_any)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign tid     = TW'(item_r.thread_id);
  assign prio    = PW'(item_r.priority_req);
  assign tid_ok  = int'(item_r.thread_id) < MAX_THREADS;
  assign prio_ok = int'(item_r.priority_req) < PRIORITY_LEVELS;

  assign ls_head = list_rdata[LSW-1:TW];
  assign ls_tail = list_rdata[TW-1:0];
  assign lk_next = link_rdata[LKW-1:TW+PW];
  assign lk_prev = link_rdata[TW+PW-1:PW];
  assign lk_lvl  = link_rdata[PW-1:0];

  assign is_head  = (ls_head == tid);
  assign is_tail  = (ls_tail == tid);
  assign is_start = (item_r.func == FN_START);
  assign lock_dec = (lock_r != '0) ? lock_r - LOCK_W'(1) : lock_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    bitmap_nxt    = bitmap_r;
    queued_nxt    = queued_r;
    run_tid_nxt   = run_tid_r;
    run_valid_nxt = run_valid_r;
    run_prio_nxt  = run_prio_r;
    lock_nxt      = lock_r;
    last_nxt      = last_r;
    nx_nxt        = nx_r;
    pv_nxt        = pv_r;
    lvl_nxt       = lvl_r;
    list_we       = 1'b0;
    list_waddr    = lvl_r;
    list_wmask    = '0;
    list_wdata    = '0;
    list_re       = 1'b0;
    list_raddr    = lvl_r;
    link_we       = 1'b0;
    link_waddr    = tid;
    link_wmask    = '0;
    link_wdata    = '0;
    link_re       = 1'b0;
    link_raddr    = tid;
    fin           = 1'b0;
    sched_go      = 1'b0;
    res           = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (item_r.func)
          FN_INSERT: begin
            if (!(tid_ok && prio_ok) || (tid_ok && queued_r[tid])) begin
              fin = 1'b1;
            end else if (bitmap_r[prio]) begin
              list_re    = 1'b1;
              list_raddr = prio;
              lvl_nxt    = prio;
              state_nxt  = S_INS_TAIL;
            end else begin
              // first thread of the level: it is head and tail, self-linked
              list_we         = 1'b1;
              list_waddr      = prio;
              list_wmask      = LS_HEAD | LS_TAIL;
              list_wdata      = {tid, tid};
              link_we         = 1'b1;
              link_waddr      = tid;
              link_wmask      = LK_ALL;
              link_wdata      = {tid, tid, prio};
              queued_nxt[tid] = 1'b1;
              bitmap_nxt[prio] = 1'b1;
              fin             = 1'b1;
            end
          end
          FN_REMOVE: begin
            if (tid_ok && queued_r[tid]) begin
              link_re    = 1'b1;
              link_raddr = tid;
              state_nxt  = S_REM_LINK;
            end else begin
              fin = 1'b1;
            end
          end
          FN_SCHED: begin
            if (lock_r == '0) begin
              sched_go = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          FN_LOCK: begin
            if (lock_r != LOCK_MAX) begin
              lock_nxt = lock_r + LOCK_W'(1);
            end
            fin = 1'b1;
          end
          FN_UNLOCK: begin
            lock_nxt = lock_dec;
            if (lock_dec == '0 && run_valid_r) begin
              sched_go = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          FN_START: begin
            sched_go = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase

        if (sched_go) begin
          if (!lsb_any) begin
            res.none_ready = 1'b1;
            fin            = 1'b1;
          end else begin
            list_re    = 1'b1;
            list_raddr = lsb_idx;
            lvl_nxt    = lsb_idx;
            state_nxt  = S_SCH_WAIT;
          end
        end
      end

      S_INS_TAIL: begin
        // append behind the old tail
        last_nxt   = ls_tail;
        link_we    = 1'b1;
        link_waddr = ls_tail;
        link_wmask = LK_NEXT;
        link_wdata = {tid, {TW{1'b0}}, {PW{1'b0}}};
        list_we    = 1'b1;
        list_waddr = lvl_r;
        list_wmask = LS_TAIL;
        list_wdata = {{TW{1'b0}}, tid};
        state_nxt  = S_INS_NEW;
      end

      S_INS_NEW: begin
        link_we           = 1'b1;
        link_waddr        = tid;
        link_wmask        = LK_ALL;
        link_wdata        = {tid, last_r, lvl_r};
        queued_nxt[tid]   = 1'b1;
        bitmap_nxt[lvl_r] = 1'b1;
        fin               = 1'b1;
      end

      S_REM_LINK: begin
        nx_nxt     = lk_next;
        pv_nxt     = lk_prev;
        lvl_nxt    = lk_lvl;
        list_re    = 1'b1;
        list_raddr = lk_lvl;
        state_nxt  = S_REM_LIST;
      end

      S_REM_LIST: begin
        if (is_head && is_tail) begin
          // last thread of the level
          bitmap_nxt[lvl_r] = 1'b0;
          queued_nxt[tid]   = 1'b0;
          fin               = 1'b1;
        end else begin
          list_we    = is_head || is_tail;
          list_waddr = lvl_r;
          list_wmask = (is_head ? LS_HEAD : '0) | (is_tail ? LS_TAIL : '0);
          list_wdata = {nx_r, pv_r};
          link_we    = 1'b1;
          if (!is_head) begin
            link_waddr = pv_r;
            link_wmask = LK_NEXT;
            link_wdata = {(is_tail ? pv_r : nx_r), {TW{1'b0}}, {PW{1'b0}}};
            if (!is_tail) begin
              state_nxt = S_REM_PREV;
            end else begin
              queued_nxt[tid] = 1'b0;
              fin             = 1'b1;
            end
          end else begin
            // new head points back at itself
            link_waddr      = nx_r;
            link_wmask      = LK_PREV;
            link_wdata      = {{TW{1'b0}}, nx_r, {PW{1'b0}}};
            queued_nxt[tid] = 1'b0;
            fin             = 1'b1;
          end
        end
      end

      S_REM_PREV: begin
        link_we         = 1'b1;
        link_waddr      = nx_r;
        link_wmask      = LK_PREV;
        link_wdata      = {{TW{1'b0}}, pv_r, {PW{1'b0}}};
        queued_nxt[tid] = 1'b0;
        fin             = 1'b1;
      end

      S_SCH_WAIT: begin
        if (is_start) begin
          run_prio_nxt = PRIO_W'(lvl_r);
        end
        if (!run_valid_r || ls_head != run_tid_r) begin
          res.switched  = 1'b1;
          res.to_thread = TID_W'(ls_head);
          if (!is_start && run_valid_r) begin
            res.from_valid = 1'b1;
            res.from_tid   = TID_W'(run_tid_r);
          end
          res.switch_from_irq = !is_start && item_r.in_interrupt;
          run_prio_nxt        = PRIO_W'(lvl_r);
          run_tid_nxt         = ls_head;
          run_valid_nxt       = 1'b1;
        end
        fin = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
    res.running_priority = run_prio_nxt;
    res.lock_level       = lock_nxt;
    out_valid_nxt        = fin;
    out_nxt              = fin ? res : out_r;
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    last_r <= last_nxt;
    nx_r   <= nx_nxt;
    pv_r   <= pv_nxt;
    lvl_r  <= lvl_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bitmap_r    <= '0;
      queued_r    <= '0;
      run_tid_r   <= '0;
      run_valid_r <= 1'b0;
      run_prio_r  <= PRIO_RESET;
      lock_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bitmap_r    <= bitmap_nxt;
      queued_r    <= queued_nxt;
      run_tid_r   <= run_tid_nxt;
      run_valid_r <= run_valid_nxt;
      run_prio_r  <= run_prio_nxt;
      lock_r      <= lock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/prq_checker.sv */
`timescale 1ns / 1ps
`include "priority_ready_queue_scheduler_assert.svh"
module prq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input prq_pkg::prq_out_t out_data
);
  import prq_pkg::*;

  `PRQ_ASSERT_RESET(a_reset_quiet, !busy && !out_valid, "busy or strobe after reset")

  // an accepted item always shows busy in the cycle after it is taken
  `PRQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item left block idle")

  // the result strobe is never held high, so each result is shown once
  `PRQ_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")

  `PRQ_ASSERT_NOW(a_switch_fields,
    out_valid && (out_data.from_valid || out_data.switch_from_irq || out_data.none_ready),
    out_data.switched != out_data.none_ready,
    "switch flags inconsistent in result item")

endmodule

bind priority_ready_queue_scheduler prq_checker u_prq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
